/* rtl/core/mrpt_pkg.sv */
// Package for the Miller-Rabin prime test: base table and constants.
// No dependencies.
package mrpt_pkg;

   localparam int MaxBases = 12;

   function automatic logic [5:0] base_at(input logic [3:0] idx);
      logic [5:0] b;
      unique case (idx)
         4'd0:    b = 6'd2;
         4'd1:    b = 6'd3;
         4'd2:    b = 6'd5;
         4'd3:    b = 6'd7;
         4'd4:    b = 6'd11;
         4'd5:    b = 6'd13;
         4'd6:    b = 6'd17;
         4'd7:    b = 6'd19;
         4'd8:    b = 6'd23;
         4'd9:    b = 6'd29;
         4'd10:   b = 6'd31;
         4'd11:   b = 6'd37;
         default: b = 6'd2;
      endcase
      return b;
   endfunction

endpackage

/* rtl/core/mrpt_if.sv */
// Valid/ready channel interface for the Miller-Rabin prime test.
// Depends on nothing; payload width is a parameter.
interface mrpt_if #(
   parameter int W = 64
) (
   input logic clock
);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/mrpt_mulmod.sv */
// Bit-serial modular multiplier: r = x*y mod m, one bit of y per cycle.
// Depends on nothing but its parameter; x, y < m assumed.
module mrpt_mulmod #(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] x,
   input  logic [WIDTH-1:0] y,
   input  logic [WIDTH-1:0] m,
   output logic             done,
   output logic [WIDTH-1:0] r
);
   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] x_ff, y_ff, m_ff, r_ff, r_in;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff, done_ff;
   logic [WIDTH:0]   dbl, dsub, sum, ssub;
   logic [WIDTH-1:0] r2;

   always_comb begin
      dbl  = {r_ff, 1'b0};
      dsub = dbl - {1'b0, m_ff};
      r2   = (dbl >= {1'b0, m_ff}) ? dsub[WIDTH-1:0] : dbl[WIDTH-1:0];
      sum  = {1'b0, r2} + {1'b0, x_ff};
      ssub = sum - {1'b0, m_ff};
      r_in = y_ff[WIDTH-1] ? ((sum >= {1'b0, m_ff}) ? ssub[WIDTH-1:0] : sum[WIDTH-1:0])
                           : r2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(WIDTH);
            x_ff    <= x;
            y_ff    <= y;
            m_ff    <= m;
            r_ff    <= '0;
         end else if (busy_ff) begin
            r_ff   <= r_in;
            y_ff   <= {y_ff[WIDTH-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign r    = r_ff;
endmodule

/* rtl/core/miller_rabin_prime_test.sv */
// Top level of the Miller-Rabin prime test: sequencer around one shared
// modular multiplier. Depends on mrpt_pkg, mrpt_if and mrpt_mulmod.
//
// Usage: one candidate item enters on req (valid/ready); one is_prime item
// leaves on rsp. The block takes one item at a time: req_ready is high only
// in idle. Values below 2 and even values are decided in S_MOD3. The
// multiple-of-3 check folds the candidate (mod 255 groups, then base 4
// digits). Otherwise each base runs a base-mod-n reduction (repeated
// compare-and-subtract), a square-and-multiply exponentiation, then up to
// s-1 squarings. Every modular multiply runs in the bit-serial multiplier
// (start, one step per bit of y, done); each exponent bit issues a square,
// preceded by a multiply into the accumulator when the bit is one.
// Reset (synchronous, active high) drops any item in flight and empties the
// output. When the receiver stalls, the result holds in the output register;
// a new item is still taken and runs, and its result waits in S_DONE until
// the output register is free.
module miller_rabin_prime_test #(
   parameter int WIDTH     = 64,
   parameter int NUM_BASES = 12
) (
   input logic clock,
   input logic reset,
   mrpt_if.sink   req,
   mrpt_if.source rsp
);
   import mrpt_pkg::*;

   localparam int CW = $clog2(WIDTH + 1);
   localparam int NB = (NUM_BASES < MaxBases) ? NUM_BASES : MaxBases;

   typedef enum logic [3:0] {
      S_IDLE, S_MOD3, S_SPLIT, S_BASE, S_BMOD, S_EXP, S_EXPW,
      S_SQW, S_CHECK, S_LOOP, S_LOOPW, S_DONE
   } state_type;

   state_type        state_ff;
   logic [WIDTH-1:0] n_ff, fold_ff, d_ff, e_ff, acc_ff, p_ff, nm1_ff;
   logic [CW-1:0]    s_ff, k_ff;
   logic [5:0]       bmod_ff;
   logic [3:0]       bi_ff;
   logic             out_valid_ff, out_bit_ff, verdict_ff;

   logic             mm_start_ff, mm_done;
   logic [WIDTH-1:0] mm_x, mm_y, mm_r;

   mrpt_mulmod #(.WIDTH(WIDTH)) u_mul (
      .clock(clock), .reset(reset), .start(mm_start_ff),
      .x(mm_x), .y(mm_y), .m(n_ff), .done(mm_done), .r(mm_r)
   );

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         mm_start_ff  <= 1'b0;
      end else begin
         mm_start_ff <= 1'b0;
         // load the output register when it is free or leaving this cycle
         if (state_ff == S_DONE && (!out_valid_ff || rsp.ready)) begin
            out_valid_ff <= 1'b1;
            out_bit_ff   <= verdict_ff;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  n_ff     <= req.data;
                  fold_ff  <= req.data;
                  state_ff <= S_MOD3;
               end
            end
            S_MOD3: begin
               // 2^8 and 4 are both 1 mod 3: fold bytes, then base 4 digits
               if (n_ff < WIDTH'(2) || !n_ff[0]) begin
                  verdict_ff <= (n_ff == WIDTH'(2));
                  state_ff   <= S_DONE;
               end else if ((fold_ff >> 8) != '0) begin
                  fold_ff <= (fold_ff >> 8) + (fold_ff & WIDTH'(8'hFF));
               end else if ((fold_ff >> 2) != '0) begin
                  fold_ff <= (fold_ff >> 2) + (fold_ff & WIDTH'(2'd3));
               end else if (fold_ff == WIDTH'(3)) begin
                  verdict_ff <= (n_ff == WIDTH'(3));
                  state_ff   <= S_DONE;
               end else begin
                  d_ff     <= n_ff - 1'b1;
                  nm1_ff   <= n_ff - 1'b1;
                  s_ff     <= '0;
                  bi_ff    <= '0;
                  state_ff <= S_SPLIT;
               end
            end
            S_SPLIT: begin
               if (!d_ff[0]) begin
                  d_ff <= d_ff >> 1;
                  s_ff <= s_ff + 1'b1;
               end else state_ff <= S_BASE;
            end
            S_BASE: begin
               if (bi_ff == 4'(NB)) begin
                  verdict_ff <= 1'b1;
                  state_ff   <= S_DONE;
               end else begin
                  bmod_ff  <= base_at(bi_ff);
                  state_ff <= S_BMOD;
               end
            end
            S_BMOD: begin
               // base mod n by repeated subtraction, applied only while n is at most the base
               if (WIDTH'(bmod_ff) >= n_ff) begin
                  bmod_ff <= bmod_ff - 6'(n_ff);
               end else if (bmod_ff == '0) begin
                  bi_ff    <= bi_ff + 1'b1;
                  state_ff <= S_BASE;
               end else begin
                  p_ff     <= WIDTH'(bmod_ff);
                  acc_ff   <= WIDTH'(1);
                  e_ff     <= d_ff;
                  state_ff <= S_EXP;
               end
            end
            S_EXP: begin
               if (e_ff == '0) begin
                  state_ff <= S_CHECK;
               end else if (e_ff[0]) begin
                  mm_start_ff <= 1'b1;
                  state_ff    <= S_EXPW;
               end else begin
                  mm_start_ff <= 1'b1;
                  state_ff    <= S_SQW;
               end
            end
            S_EXPW: begin
               if (mm_done) begin
                  acc_ff      <= mm_r;
                  mm_start_ff <= 1'b1;
                  state_ff    <= S_SQW;
               end
            end
            S_SQW: begin
               if (mm_done) begin
                  p_ff     <= mm_r;
                  e_ff     <= e_ff >> 1;
                  state_ff <= S_EXP;
               end
            end
            S_CHECK: begin
               if (acc_ff == WIDTH'(1) || acc_ff == nm1_ff) begin
                  bi_ff    <= bi_ff + 1'b1;
                  state_ff <= S_BASE;
               end else begin
                  k_ff     <= CW'(1);
                  state_ff <= S_LOOP;
               end
            end
            S_LOOP: begin
               if (k_ff >= s_ff) begin
                  verdict_ff <= 1'b0;
                  state_ff   <= S_DONE;
               end else begin
                  mm_start_ff <= 1'b1;
                  state_ff    <= S_LOOPW;
               end
            end
            S_LOOPW: begin
               if (mm_done) begin
                  acc_ff <= mm_r;
                  k_ff   <= k_ff + 1'b1;
                  if (mm_r == nm1_ff) begin
                     bi_ff    <= bi_ff + 1'b1;
                     state_ff <= S_BASE;
                  end else if (mm_r == WIDTH'(1)) begin
                     verdict_ff <= 1'b0;
                     state_ff   <= S_DONE;
                  end else state_ff <= S_LOOP;
               end
            end
            S_DONE: begin
               // hold here while the previous result still waits
               if (!out_valid_ff || rsp.ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // multiplier operands, taken by the multiplier in the cycle start is high:
   // acc*p in the exponent multiply, p*p in the exponent square, else acc*acc
   always_comb begin
      unique case (state_ff)
         S_EXPW: begin
            mm_x = acc_ff; mm_y = p_ff;
         end
         S_SQW: begin
            mm_x = p_ff; mm_y = p_ff;
         end
         default: begin
            mm_x = acc_ff; mm_y = acc_ff;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)))
      else $error("result dropped under stall");
   a_done_set: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> out_valid_ff) else $error("result lost");
`endif
endmodule

/* sim/tb_top.sv */
// Self-checking bench for miller_rabin_prime_test: directed table, then random
// candidates checked against a local primality predictor.
// Depends on mrpt_if and the RTL of the block (which uses mrpt_pkg).
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIDTH     = 64;
   localparam int NUM_BASES = 12;
   // watchdog limit: above the worst case per item, with margin for stalls
   localparam int StallLimit = 1000000;

   typedef struct {
      logic [63:0] candidate;
      logic        check;      // typed-in answer present
      logic        prime;
   } cand_row_type;

   logic clock;
   logic reset;

   mrpt_if #(.W(WIDTH)) req_ch (.clock(clock));
   mrpt_if #(.W(1))     rsp_ch (.clock(clock));

   miller_rabin_prime_test #(.WIDTH(WIDTH), .NUM_BASES(NUM_BASES)) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch.sink),
      .rsp  (rsp_ch.source)
   );

   // sample handshakes just before each rising edge
   clocking mon_cb @(posedge clock);
      input req_valid = req_ch.valid;
      input req_ready = req_ch.ready;
      input rsp_valid = rsp_ch.valid;
      input rsp_ready = rsp_ch.ready;
      input rsp_data  = rsp_ch.data;
   endclocking

   logic        verdict_q[$];
   int          failures;
   int          table_errors;
   int          idle_cycles;
   int          send_idle_pct;
   int          recv_idle_pct;
   logic        stim_done;

   // ---------------------------------------------------------------
   // Predictor: exact modular arithmetic through 128-bit products.
   // ---------------------------------------------------------------
   function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return 64'(p % {64'd0, m});
   endfunction

   function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
      logic [63:0] acc;
      logic [63:0] sq;
      acc = 64'd1 % m;
      sq  = b % m;
      while (e != 0) begin
         if (e[0]) acc = mulmod(acc, sq, m);
         sq = mulmod(sq, sq, m);
         e  = e >> 1;
      end
      return acc;
   endfunction

   function automatic logic predict_prime(logic [63:0] n);
      logic [63:0] bases [12];
      logic [63:0] d;
      logic [63:0] x;
      int          s;
      logic        pass;
      bases = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
      if (n < 2) return 1'b0;
      if (!n[0]) return n == 2;
      if (n % 3 == 0) return n == 3;
      d = n - 1;
      s = 0;
      while (!d[0]) begin
         d = d >> 1;
         s++;
      end
      for (int i = 0; i < NUM_BASES && i < 12; i++) begin
         if (bases[i] % n == 0) continue;
         x = powmod(bases[i], d, n);
         pass = (x == 1) || (x == n - 1);
         for (int k = 1; k < s && !pass; k++) begin
            x = mulmod(x, x, n);
            if (x == n - 1) pass = 1'b1;
            else if (x == 1) break;
         end
         if (!pass) return 1'b0;
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // Clock and reset.
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Drive one candidate item; hold valid until accepted.
   // Entered and left at a falling edge.
   // ---------------------------------------------------------------
   task automatic send_candidate(logic [63:0] n, logic check, logic prime);
      logic want;
      want = check ? prime : predict_prime(n);
      if (check && predict_prime(n) != prime) begin
         $error("table row for %0d disagrees with predictor", n);
         table_errors++;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= n;
      do @(mon_cb); while (!mon_cb.req_ready);
      // item taken at this edge: queue its verdict
      verdict_q = {verdict_q, want};
      @(negedge clock);
   endtask

   // random odd value of given bit length, top bit set
   function automatic logic [63:0] rand_odd(int bits);
      logic [63:0] v;
      v = {$urandom, $urandom};
      if (bits < 64) v = v & ((64'd1 << bits) - 1);
      v[bits-1] = 1'b1;
      v[0] = 1'b1;
      return v;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------
   initial begin
      cand_row_type table_rows [23];
      logic [63:0] n;
      int          phase;
      table_rows = '{
         '{64'd0, 1, 0}, '{64'd1, 1, 0}, '{64'd2, 1, 1}, '{64'd3, 1, 1},
         '{64'd4, 1, 0}, '{64'd5, 1, 1}, '{64'd9, 1, 0}, '{64'd37, 1, 1},
         '{64'd41, 1, 1}, '{64'd561, 1, 0}, '{64'd3215031751, 1, 0},
         '{64'hFFFF_FFFF_FFFF_FFFF, 1, 0}, '{64'hFFFF_FFFF_FFFF_FFC5, 1, 1},
         '{64'hFFFF_FFFF_FFFF_FFFE, 1, 0}, '{64'h8000_0000_0000_0000, 1, 0},
         '{64'd3825123056546413051, 0, 0}, '{64'd341550071728321, 0, 0},
         '{64'd2147483647, 1, 1}, '{64'd2305843009213693951, 1, 1},
         '{64'd1000000007, 0, 0}, '{64'd25, 0, 0}, '{64'd49, 0, 0},
         '{64'd2047, 0, 0}
      };
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      stim_done    = 1'b0;
      table_errors = 0;
      send_idle_pct = 18;
      recv_idle_pct = 59;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (table_rows[i])
         send_candidate(table_rows[i].candidate, table_rows[i].check, table_rows[i].prime);

      // random part in three idling phases
      for (int k = 0; k < 77; k++) begin
         phase = k / 26;
         send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 59 : 0;
         recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 18 : 0;
         case ($urandom_range(9))
            0: n = {$urandom, $urandom};          // raw noise, covers every bit
            1: n = ~{$urandom, $urandom};
            2: n = $urandom_range(200);
            default: n = rand_odd($urandom_range(3) == 0 ? 64 : $urandom_range(8, 40));
         endcase
         send_candidate(n, 1'b0, 1'b0);
      end
      req_ch.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // ---------------------------------------------------------------
   // Receiver: random back-pressure, verdict check.
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   initial failures = 0;

   always @(mon_cb) begin
      if (!reset && mon_cb.rsp_valid && mon_cb.rsp_ready) begin
         if (verdict_q.size() == 0) begin
            $error("unexpected is_prime item %0b", mon_cb.rsp_data[0]);
            failures++;
         end else begin
            logic want;
            want = verdict_q.pop_front();
            if (mon_cb.rsp_data[0] !== want) begin
               $error("is_prime mismatch: expected %0b actual %0b", want,
                      mon_cb.rsp_data[0]);
               failures++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Watchdog and end of run.
   // ---------------------------------------------------------------
   always @(mon_cb) begin
      if (reset || (mon_cb.req_valid && mon_cb.req_ready) ||
          (mon_cb.rsp_valid && mon_cb.rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (idle_cycles >= StallLimit) begin
            $display("[FAIL] regression broken");
            $finish;
         end
         if (stim_done && verdict_q.size() == 0) begin
            repeat (200) @(posedge clock);
            if (failures == 0 && table_errors == 0 && verdict_q.size() == 0)
               $display("[ OK ] regression clean");
            else
               $display("[FAIL] regression broken");
            $finish;
         end
      end
   end
endmodule

/* miller_rabin_prime_test.f */
rtl/core/mrpt_pkg.sv
rtl/core/mrpt_if.sv
rtl/core/mrpt_mulmod.sv
rtl/core/miller_rabin_prime_test.sv
sim/tb_top.sv
